/* rtl/core/u2cb_pkg.sv */
// Shared types, constants and the CRC-16 byte step for the serial-to-CAN bridge.
// No dependencies.
`timescale 1ns / 1ps

package u2cb_pkg;

   localparam logic [7:0]  HDR_START = 8'hC0;
   localparam logic [15:0] CRC_POLY  = 16'hA001;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam int          SRC_W     = 5;
   localparam int          HDR_BYTES = 8;
   localparam int          STG_BYTES = 8;
   localparam int          LEFT_W    = 17;
   localparam int          CNT_W     = 4;
   localparam int          FCNT_W    = 16;
   localparam int          ID_W      = 21;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic                  hit;
      logic [SRC_W-1:0]      src;
      logic [15:0]           pid;
      logic [15:0]           len;
   } hdr_info_type;

   // reflected CRC-16, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input byte_type b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* rtl/core/u2cb_if.sv */
// Valid/ready channel interfaces for the bridge: serial byte in, CAN frame out.
// Depends on u2cb_pkg.
`timescale 1ns / 1ps

interface u2cb_req_if;
   import u2cb_pkg::*;
   logic     valid;
   logic     ready;
   byte_type rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface u2cb_rsp_if;
   import u2cb_pkg::*;
   logic            valid;
   logic            ready;
   logic [ID_W-1:0] frame_id;
   logic [3:0]      frame_len;
   byte_type        byte0;
   byte_type        byte1;
   byte_type        byte2;
   byte_type        byte3;
   byte_type        byte4;
   byte_type        byte5;
   byte_type        byte6;
   byte_type        byte7;
   logic            packet_end;
   modport source (output valid, output frame_id, output frame_len,
                   output byte0, output byte1, output byte2, output byte3,
                   output byte4, output byte5, output byte6, output byte7,
                   output packet_end, input ready);
   modport sink   (input valid, input frame_id, input frame_len,
                   input byte0, input byte1, input byte2, input byte3,
                   input byte4, input byte5, input byte6, input byte7,
                   input packet_end, output ready);
endinterface

/* rtl/core/u2cb_hdr_check.sv */
// Header window check: start byte and CRC-16 over the first six bytes.
// Depends on u2cb_pkg.
`timescale 1ns / 1ps

module u2cb_hdr_check (
   input  u2cb_pkg::byte_type     window [u2cb_pkg::HDR_BYTES],
   output u2cb_pkg::hdr_info_type info
);
   import u2cb_pkg::*;

   logic [15:0] crc;
   logic [15:0] rx_crc;

   always_comb begin
      crc = CRC_INIT;
      for (int i = 0; i < 6; i++) begin
         crc = crc_byte(crc, window[i]);
      end
   end

   assign rx_crc   = {window[7], window[6]};
   assign info.hit = (window[0] == HDR_START) && (crc == rx_crc);
   assign info.src = window[1][SRC_W-1:0];
   assign info.pid = {window[3], window[2]};
   assign info.len = {window[5], window[4]};

endmodule

/* rtl/core/uart_to_can_frame_bridge_core.sv */
// Serial-to-CAN framing bridge top level: header hunt, staging buffer, frame output.
// Depends on u2cb_pkg, u2cb_if and u2cb_hdr_check.
// Path: byte beat accepted into the input register, frame beat valid from the result register.
// Throughput: one byte per cycle while the result side takes frames.
// Reset (synchronous, active high) clears window, staging buffer, counters and valids.
`timescale 1ns / 1ps

module uart_to_can_frame_bridge_core (
   input  logic       clock,
   input  logic       reset,
   u2cb_req_if.sink   req_chan,
   u2cb_rsp_if.source rsp_chan
);
   import u2cb_pkg::*;

   typedef enum logic {HUNT, FORWARD} phase_type;

   phase_type          phase_ff,    phase_in;
   byte_type           window_ff    [HDR_BYTES];
   byte_type           window_in    [HDR_BYTES];
   byte_type           stage_ff     [STG_BYTES];
   byte_type           stage_in     [STG_BYTES];
   logic [LEFT_W-1:0]  left_ff,     left_in;
   logic [SRC_W-1:0]   src_ff,      src_in;
   logic [CNT_W-1:0]   cnt_ff,      cnt_in;
   logic [FCNT_W-1:0]  fcnt_ff,     fcnt_in;

   logic               in_valid_ff;
   byte_type           in_byte_ff;

   logic               out_valid_ff;
   logic [ID_W-1:0]    out_id_ff;
   logic [3:0]         out_len_ff;
   byte_type           out_data_ff  [STG_BYTES];
   logic               out_end_ff;

   byte_type           shifted      [HDR_BYTES];
   hdr_info_type       hdr;
   logic               advance;
   logic               emit;
   logic               last;
   logic [CNT_W-1:0]   cnt_inc;
   logic [LEFT_W-1:0]  left_dec;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      for (int i = 0; i < HDR_BYTES - 1; i++) begin
         shifted[i] = window_ff[i+1];
      end
      shifted[HDR_BYTES-1] = in_byte_ff;
   end

   u2cb_hdr_check hdr_check_inst (
      .window (shifted),
      .info   (hdr)
   );

   assign cnt_inc  = cnt_ff + 1'b1;
   assign left_dec = left_ff - 1'b1;
   assign last     = (left_dec == '0);

   always_comb begin
      phase_in  = phase_ff;
      window_in = window_ff;
      stage_in  = stage_ff;
      left_in   = left_ff;
      src_in    = src_ff;
      cnt_in    = cnt_ff;
      fcnt_in   = fcnt_ff;
      emit      = 1'b0;
      unique case (phase_ff)
         HUNT: begin
            window_in = shifted;
            if (hdr.hit) begin
               src_in      = hdr.src;
               fcnt_in     = '0;
               stage_in[0] = hdr.pid[7:0];
               stage_in[1] = hdr.pid[15:8];
               stage_in[2] = hdr.len[7:0];
               stage_in[3] = hdr.len[15:8];
               cnt_in      = CNT_W'(4);
               left_in     = LEFT_W'(hdr.len) + LEFT_W'(2);
               phase_in    = FORWARD;
            end
         end
         FORWARD: begin
            stage_in[cnt_ff[2:0]] = in_byte_ff;
            left_in = left_dec;
            emit    = cnt_inc[3] || last;
            cnt_in  = emit ? '0 : cnt_inc;
            if (emit) begin
               fcnt_in = fcnt_ff + 1'b1;
            end
            if (last) begin
               for (int i = 0; i < HDR_BYTES; i++) begin
                  window_in[i] = '0;
               end
               phase_in = HUNT;
            end
         end
         default: begin
            phase_in = HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= HUNT;
         left_ff      <= '0;
         src_ff       <= '0;
         cnt_ff       <= '0;
         fcnt_ff      <= '0;
         for (int i = 0; i < HDR_BYTES; i++) begin
            window_ff[i] <= '0;
         end
         for (int i = 0; i < STG_BYTES; i++) begin
            stage_ff[i] <= '0;
         end
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            phase_ff  <= phase_in;
            window_ff <= window_in;
            stage_ff  <= stage_in;
            left_ff   <= left_in;
            src_ff    <= src_in;
            cnt_ff    <= cnt_in;
            fcnt_ff   <= fcnt_in;
         end
         if (advance && emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (advance && emit) begin
         out_id_ff   <= {src_ff, fcnt_ff};
         out_len_ff  <= cnt_inc;
         out_data_ff <= stage_in;
         out_end_ff  <= last;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.frame_id   = out_id_ff;
   assign rsp_chan.frame_len  = out_len_ff;
   assign rsp_chan.byte0      = out_data_ff[0];
   assign rsp_chan.byte1      = out_data_ff[1];
   assign rsp_chan.byte2      = out_data_ff[2];
   assign rsp_chan.byte3      = out_data_ff[3];
   assign rsp_chan.byte4      = out_data_ff[4];
   assign rsp_chan.byte5      = out_data_ff[5];
   assign rsp_chan.byte6      = out_data_ff[6];
   assign rsp_chan.byte7      = out_data_ff[7];
   assign rsp_chan.packet_end = out_end_ff;

endmodule

/* tb/uart_to_can_frame_bridge_core_test.sv */
// Self-checking testbench for uart_to_can_frame_bridge_core: serial bytes in, CAN frames out.
// A directed table, then random packets, checked against an in-bench frame predictor.
// Depends on u2cb_pkg, u2cb_if and the bridge RTL.
`timescale 1ns / 1ps

module uart_to_can_frame_bridge_core_test;
   import u2cb_pkg::*;

   localparam int GOOD_ITEMS  = 1050;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_TAIL  = 10;

   typedef enum logic [1:0] {ROW_LIT, ROW_CRC_LO, ROW_CRC_LO_BAD, ROW_CRC_HI} row_kind_type;

   typedef struct packed {
      logic [ID_W-1:0]  frame_id;
      logic [3:0]       frame_len;
      logic [7:0][7:0]  data;
      logic             packet_end;
   } can_frame_type;

   typedef struct packed {
      row_kind_type  kind;
      byte_type      val;
      logic          typed;
      can_frame_type want;
   } stim_row_type;

   localparam can_frame_type NO_FRAME = '0;

   // zero-length packet, rejected header, packet ending on a full frame
   localparam stim_row_type DIRECTED_ROWS [30] = '{
      '{ROW_LIT,        8'hC0, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'hFF, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'hFF, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'hFF, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'h00, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'h00, 1'b0, NO_FRAME},
      '{ROW_CRC_LO,     8'h00, 1'b0, NO_FRAME},
      '{ROW_CRC_HI,     8'h00, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'hFF, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'h00, 1'b1,
        '{21'h1F0000, 4'd6, 64'h000000FF_0000FFFF, 1'b1}},
      '{ROW_LIT,        8'hC0, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'hFF, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'hFF, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'hFF, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'hFF, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'hFF, 1'b0, NO_FRAME},
      '{ROW_CRC_LO_BAD, 8'h00, 1'b0, NO_FRAME},
      '{ROW_CRC_HI,     8'h00, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'hC0, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'h00, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'h00, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'h00, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'h02, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'h00, 1'b0, NO_FRAME},
      '{ROW_CRC_LO,     8'h00, 1'b0, NO_FRAME},
      '{ROW_CRC_HI,     8'h00, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'h01, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'h80, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'hAA, 1'b0, NO_FRAME},
      '{ROW_LIT,        8'h55, 1'b1,
        '{21'h000000, 4'd8, 64'h55AA8001_00020000, 1'b1}}
   };

   logic clock = 1'b0;
   logic reset;

   u2cb_req_if req_bus ();
   u2cb_rsp_if rsp_bus ();

   uart_to_can_frame_bridge_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [7:0][7:0]   hdr_win;
   logic              fwd_phase;
   logic [LEFT_W-1:0] bytes_due;
   logic [SRC_W-1:0]  src_id;
   logic [7:0][7:0]   stage;
   logic [CNT_W-1:0]  stage_cnt;
   logic [FCNT_W-1:0] frame_cnt;

   can_frame_type   frames_due [$];
   logic [5:0][7:0] sent_hist;
   logic            calm;
   bit              failed = 1'b0;
   int              sent_items = 0;
   can_frame_type   rsp_want;
   logic [7:0][7:0] rsp_bytes;

   function automatic logic [15:0] crc16_next(input logic [15:0] acc, input byte_type d);
      logic [15:0] r;
      r = acc ^ {8'h00, d};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   // CRC over the last six bytes sent, oldest first
   function automatic logic [15:0] hist_crc(input logic [5:0][7:0] h);
      logic [15:0] c;
      c = CRC_INIT;
      for (int i = 5; i >= 0; i--) begin
         c = crc16_next(c, h[i]);
      end
      return c;
   endfunction

   task automatic bridge_predict(input byte_type b, output logic got, output can_frame_type fr);
      logic [15:0] c;
      logic        lastb;
      got = 1'b0;
      fr  = '0;
      if (!fwd_phase) begin
         for (int i = 0; i < 7; i++) begin
            hdr_win[i] = hdr_win[i+1];
         end
         hdr_win[7] = b;
         if (hdr_win[0] == HDR_START) begin
            c = CRC_INIT;
            for (int i = 0; i < 6; i++) begin
               c = crc16_next(c, hdr_win[i]);
            end
            if (c == {hdr_win[7], hdr_win[6]}) begin
               src_id    = hdr_win[1][SRC_W-1:0];
               frame_cnt = '0;
               for (int i = 0; i < 4; i++) begin
                  stage[i] = hdr_win[2+i];
               end
               stage_cnt = 4'd4;
               bytes_due = {1'b0, hdr_win[5], hdr_win[4]} + 17'd2;
               fwd_phase = 1'b1;
            end
         end
      end else begin
         stage[stage_cnt[2:0]] = b;
         stage_cnt = stage_cnt + 4'd1;
         bytes_due = bytes_due - 17'd1;
         lastb     = (bytes_due == '0);
         if (stage_cnt >= 4'd8 || (lastb && stage_cnt > 4'd0)) begin
            fr.frame_id   = {src_id, frame_cnt};
            fr.frame_len  = stage_cnt;
            fr.data       = stage;
            fr.packet_end = lastb;
            got           = 1'b1;
            frame_cnt     = frame_cnt + 16'd1;
            stage_cnt     = '0;
         end
         if (lastb) begin
            hdr_win   = '0;
            fwd_phase = 1'b0;
         end
      end
   endtask

   task automatic send_byte(input byte_type b, input logic typed, input can_frame_type typed_fr);
      logic          got;
      can_frame_type fr;
      if (!calm && $urandom_range(0, 99) < 12) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < 12) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_items++;
      sent_hist = {sent_hist[4:0], b};
      bridge_predict(b, got, fr);
      if (typed) begin
         frames_due.push_back(typed_fr);
      end else if (got) begin
         frames_due.push_back(fr);
      end
   endtask

   task automatic send_header(input byte_type src, input logic [15:0] pid,
                              input logic [15:0] len, input byte_type crc_flip);
      logic [15:0] c;
      send_byte(HDR_START, 1'b0, NO_FRAME);
      send_byte(src, 1'b0, NO_FRAME);
      send_byte(pid[7:0], 1'b0, NO_FRAME);
      send_byte(pid[15:8], 1'b0, NO_FRAME);
      send_byte(len[7:0], 1'b0, NO_FRAME);
      send_byte(len[15:8], 1'b0, NO_FRAME);
      c = hist_crc(sent_hist);
      send_byte(c[7:0] ^ crc_flip, 1'b0, NO_FRAME);
      send_byte(c[15:8], 1'b0, NO_FRAME);
   endtask

   initial begin : stimulus
      logic [15:0] row_crc;
      byte_type    b;
      int          pick;
      int          len;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= '0;
      hdr_win    = '0;
      fwd_phase  = 1'b0;
      bytes_due  = '0;
      src_id     = '0;
      stage      = '0;
      stage_cnt  = '0;
      frame_cnt  = '0;
      sent_hist  = '0;
      calm       = 1'b0;
      row_crc    = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         case (DIRECTED_ROWS[i].kind)
            ROW_CRC_LO: begin
               row_crc = hist_crc(sent_hist);
               b = row_crc[7:0];
            end
            ROW_CRC_LO_BAD: begin
               row_crc = hist_crc(sent_hist);
               b = row_crc[7:0] ^ 8'h01;
            end
            ROW_CRC_HI: begin
               b = row_crc[15:8];
            end
            default: begin
               b = DIRECTED_ROWS[i].val;
            end
         endcase
         send_byte(b, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end

      while (sent_items < GOOD_ITEMS) begin
         calm = (sent_items >= 450 && sent_items < 650);
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               len = $urandom_range(0, 12);
            end else if (pick < 95) begin
               len = $urandom_range(13, 40);
            end else begin
               len = $urandom_range(256, 600);
            end
            if (len + 10 > GOOD_ITEMS - sent_items) begin
               len = $urandom_range(0, 12);
            end
            send_header(byte_type'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                        16'(len), 8'h00);
            repeat (len + 2) send_byte(byte_type'($urandom_range(0, 255)), 1'b0, NO_FRAME);
         end else if (pick < 80) begin
            send_header(byte_type'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), byte_type'($urandom_range(1, 255)));
         end else if (pick < 90) begin
            send_byte(HDR_START, 1'b0, NO_FRAME);
            repeat ($urandom_range(0, 6))
               send_byte(byte_type'($urandom_range(0, 255)), 1'b0, NO_FRAME);
         end else begin
            repeat ($urandom_range(1, 5))
               send_byte(byte_type'($urandom_range(0, 255)), 1'b0, NO_FRAME);
         end
      end
      req_bus.valid <= 1'b0;

      while (frames_due.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
      if (!failed && frames_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (frames_due.size() == 0) begin
               $error("frame beat with no frame expected: frame_id %0h", rsp_bus.frame_id);
               failed = 1'b1;
            end else begin
               rsp_want  = frames_due.pop_front();
               rsp_bytes = {rsp_bus.byte7, rsp_bus.byte6, rsp_bus.byte5, rsp_bus.byte4,
                            rsp_bus.byte3, rsp_bus.byte2, rsp_bus.byte1, rsp_bus.byte0};
               if (rsp_bus.frame_id !== rsp_want.frame_id) begin
                  $error("frame_id: expected %0h, actual %0h",
                         rsp_want.frame_id, rsp_bus.frame_id);
                  failed = 1'b1;
               end
               if (rsp_bus.frame_len !== rsp_want.frame_len) begin
                  $error("frame_len: expected %0d, actual %0d",
                         rsp_want.frame_len, rsp_bus.frame_len);
                  failed = 1'b1;
               end
               for (int j = 0; j < 8; j++) begin
                  if (rsp_bytes[j] !== rsp_want.data[j]) begin
                     $error("byte%0d: expected %0h, actual %0h",
                            j, rsp_want.data[j], rsp_bytes[j]);
                     failed = 1'b1;
                  end
               end
               if (rsp_bus.packet_end !== rsp_want.packet_end) begin
                  $error("packet_end: expected %0b, actual %0b",
                         rsp_want.packet_end, rsp_bus.packet_end);
                  failed = 1'b1;
               end
            end
         end
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 12);
      end
   end

   initial begin : watchdog
      int stall_cnt;
      stall_cnt = 0;
      while (stall_cnt < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            stall_cnt = 0;
         end else begin
            stall_cnt++;
         end
      end
      $error("no beat accepted for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

endmodule
